[rtl/core/cma_pkg.sv]
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types, constants and the milliampere conversion for the current
// moving average block.
// ----------------------------------------------------------------------------
package cma_pkg;

  localparam int ADC_W          = 12;
  localparam int MA_W           = 13;
  localparam int MA_NUMER       = 3300;
  localparam int MA_DENOM_LOG2  = 11;
  localparam int PROD_W         = 2 * ADC_W;
  localparam int DEPTH_LOG2_DEF = 8;

  localparam logic OP_PUSH    = 1'b0;
  localparam logic OP_PRELOAD = 1'b1;

  typedef struct packed {
    logic             op;
    logic [ADC_W-1:0] adc_sample;
  } cma_in_t;

  typedef struct packed {
    logic [MA_W-1:0] sample_ma;
    logic [MA_W-1:0] average_ma;
  } cma_out_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  function automatic logic [MA_W-1:0] to_ma(input logic [ADC_W-1:0] adc);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(adc) * PROD_W'(MA_NUMER);
    return prod[MA_DENOM_LOG2 +: MA_W];
  endfunction

endpackage

[rtl/core/cma_cell.sv]
// ----------------------------------------------------------------------------
// cma_cell
// One window entry: takes its neighbor's value on a shift, the broadcast
// value on a load, and holds otherwise.
// ----------------------------------------------------------------------------
module cma_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cma_pkg::cell_ctrl_t      ctrl,
  input  logic [cma_pkg::MA_W-1:0] prev_val,
  input  logic [cma_pkg::MA_W-1:0] load_val,
  output logic [cma_pkg::MA_W-1:0] val
);
  import cma_pkg::*;

  logic [MA_W-1:0] val_r;
  logic [MA_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.load) begin
      val_nxt = load_val;
    end else if (ctrl.shift) begin
      val_nxt = prev_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

[rtl/core/cma_chain.sv]
// ----------------------------------------------------------------------------
// cma_chain
// Row of window cells. A shift moves every entry one place toward the end
// and drops the oldest; a load fills every cell with the same value.
// ----------------------------------------------------------------------------
module cma_chain #(
  parameter int DEPTH_LOG2 = cma_pkg::DEPTH_LOG2_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cma_pkg::cell_ctrl_t      ctrl,
  input  logic [cma_pkg::MA_W-1:0] new_val,
  output logic [cma_pkg::MA_W-1:0] oldest_val
);
  import cma_pkg::*;

  localparam int DEPTH = 1 << DEPTH_LOG2;

  logic [MA_W-1:0] taps [DEPTH];

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [MA_W-1:0] prev;
      if (g == 0) begin : g_head
        assign prev = new_val;
      end else begin : g_body
        assign prev = taps[g-1];
      end
      cma_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .prev_val (prev),
        .load_val (new_val),
        .val      (taps[g])
      );
    end
  endgenerate

  assign oldest_val = taps[DEPTH-1];

endmodule

[rtl/core/current_moving_average.sv]
// ----------------------------------------------------------------------------
// current_moving_average
// Converts a current-sense reading to milliamperes and keeps a boxcar
// average over a window of 2^DEPTH_LOG2 converted samples.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_data   (op, adc_sample)
//  out     | output    | out_valid / out_ready | out_data  (sample_ma, average_ma)
//
//  The accept cycle registers the converted sample; the update step that
//  follows updates the cell row and total and loads the output register.
//  A preload fills every cell in that same update step. No new item is
//  accepted until the update is done, and the update waits while a previous result is still held unread.
//  Reset (rst_n, synchronous) zeroes the cells, the total and out_valid.
// ----------------------------------------------------------------------------
module current_moving_average #(
  parameter int DEPTH_LOG2 = cma_pkg::DEPTH_LOG2_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cma_pkg::cma_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cma_pkg::cma_out_t out_data
);
  import cma_pkg::*;

  localparam int TOTAL_W = MA_W + DEPTH_LOG2;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic              state_r, state_nxt;
  logic              op_r;
  logic [MA_W-1:0]   ma_r;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic              out_valid_r, out_valid_nxt;
  cma_out_t          out_data_r, out_data_nxt;

  logic              in_fire;
  logic              do_upd;
  cell_ctrl_t        ctrl;
  logic [MA_W-1:0]   oldest;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign do_upd   = (state_r == ST_UPD) && (!out_valid_r || out_ready);

  assign ctrl.shift = do_upd && (op_r == OP_PUSH);
  assign ctrl.load  = do_upd && (op_r == OP_PRELOAD);

  cma_chain #(
    .DEPTH_LOG2 (DEPTH_LOG2)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .new_val    (ma_r),
    .oldest_val (oldest)
  );

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      state_nxt = ST_UPD;
    end
    if (do_upd) begin
      state_nxt = ST_IDLE;
      if (op_r == OP_PRELOAD) begin
        total_nxt = {ma_r, {DEPTH_LOG2{1'b0}}};
      end else begin
        total_nxt = total_r - TOTAL_W'(oldest) + TOTAL_W'(ma_r);
      end
      out_valid_nxt           = 1'b1;
      out_data_nxt.sample_ma  = ma_r;
      out_data_nxt.average_ma = total_nxt[TOTAL_W-1:DEPTH_LOG2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      op_r <= in_data.op;
      ma_r <= to_ma(in_data.adc_sample);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sim/current_moving_average_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// current_moving_average_tb
// Drives raw converter readings as push and preload items through the
// valid/ready input channel, tracks the 256-entry window, the write index
// and the running total alongside the block, and checks every result item
// field by field. Both channels idle at random, with one long stretch in
// which neither side idles.
// ----------------------------------------------------------------------------
module current_moving_average_tb;
  import cma_pkg::*;

  localparam int DEPTH_LOG2  = 8;
  localparam int WINDOW_LEN  = 1 << DEPTH_LOG2;
  localparam int TOTAL_W     = MA_W + DEPTH_LOG2;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  cma_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  cma_out_t out_data;

  logic [MA_W-1:0]       window_ma [WINDOW_LEN];
  logic [DEPTH_LOG2-1:0] write_idx = '0;
  logic [TOTAL_W-1:0]    window_total = '0;
  cma_out_t              pending_results [$];
  int                    error_count = 0;
  int                    cycle_count = 0;
  bit                    steady = 1'b0;

  current_moving_average #(
    .DEPTH_LOG2(DEPTH_LOG2)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < WINDOW_LEN; i++) window_ma[i] = '0;
  end

  function automatic bit idle_draw();
    return !steady && ($urandom_range(0, 99) < 20);
  endfunction

  function automatic logic [MA_W-1:0] adc_to_milliamps(logic [ADC_W-1:0] adc);
    logic [31:0] scaled;
    scaled = (32'(adc) * 32'd3300) >> 11;
    return scaled[MA_W-1:0];
  endfunction

  function automatic cma_out_t update_window(cma_in_t item);
    cma_out_t res;
    logic [MA_W-1:0] ma;
    ma = adc_to_milliamps(item.adc_sample);
    res.sample_ma = ma;
    if (item.op == OP_PRELOAD) begin
      for (int i = 0; i < WINDOW_LEN; i++) window_ma[i] = ma;
      window_total = TOTAL_W'(ma) << DEPTH_LOG2;
      write_idx = '0;
      res.average_ma = ma;
    end else begin
      window_total = window_total - TOTAL_W'(window_ma[write_idx]) + TOTAL_W'(ma);
      window_ma[write_idx] = ma;
      write_idx = write_idx + 1'b1;
      res.average_ma = MA_W'(window_total >> DEPTH_LOG2);
    end
    return res;
  endfunction

  task automatic send_item(logic op, logic [ADC_W-1:0] adc);
    cma_in_t item;
    item.op = op;
    item.adc_sample = adc;
    while (idle_draw()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(update_window(item));
  endtask

  task automatic test_reset_ramp();
    send_item(OP_PUSH, 12'd4095);
    send_item(OP_PUSH, 12'd4095);
    send_item(OP_PUSH, 12'd4095);
    send_item(OP_PUSH, 12'd0);
    send_item(OP_PUSH, 12'd1);
    send_item(OP_PUSH, 12'd2048);
    send_item(OP_PUSH, 12'hAAA);
    send_item(OP_PUSH, 12'h555);
  endtask

  task automatic test_preload_extremes();
    send_item(OP_PRELOAD, 12'd4095);
    send_item(OP_PUSH, 12'd0);
    send_item(OP_PUSH, 12'd0);
    send_item(OP_PRELOAD, 12'd0);
    send_item(OP_PUSH, 12'd4095);
    send_item(OP_PUSH, 12'd4095);
    send_item(OP_PRELOAD, 12'd2048);
    send_item(OP_PRELOAD, 12'd1);
    send_item(OP_PUSH, 12'd4094);
    send_item(OP_PRELOAD, 12'hFFF);
    send_item(OP_PUSH, 12'd1);
  endtask

  task automatic test_push_wrap();
    for (int n = 0; n < 600; n++) begin
      steady = (n >= 250) && (n < 550);
      send_item(OP_PUSH, 12'($urandom_range(0, 4095)));
    end
    steady = 1'b0;
  endtask

  task automatic test_mixed_ops();
    logic op;
    for (int n = 0; n < 500; n++) begin
      op = ($urandom_range(0, 99) < 6) ? OP_PRELOAD : OP_PUSH;
      case ($urandom_range(0, 9))
        0:       send_item(op, 12'd0);
        1:       send_item(op, 12'd4095);
        default: send_item(op, 12'($urandom_range(0, 4095)));
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_ramp();
    test_preload_extremes();
    test_push_wrap();
    test_mixed_ops();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= !idle_draw();
  end

  always @(posedge clk) begin
    cma_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: sample_ma %0d average_ma %0d",
               out_data.sample_ma, out_data.average_ma);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.sample_ma !== want.sample_ma) begin
          $error("sample_ma: expected %0d, actual %0d", want.sample_ma, out_data.sample_ma);
          error_count++;
        end
        if (out_data.average_ma !== want.average_ma) begin
          $error("average_ma: expected %0d, actual %0d",
                 want.average_ma, out_data.average_ma);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
